// File: sv/ppcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_pkg: shared types and constants for point-pair cosine compatibility
// Widths of the point tables, the dot-product datapath and the square-root
// pipeline, plus the action codes and the side-band record of a query.
// ----------------------------------------------------------------------------
package ppcc_pkg;

  // Point tables
  localparam int unsigned IdxW   = 6;
  localparam int unsigned Depth  = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned PointW = 3 * CoordW;

  // Datapath widths
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned MagW   = ProdW;
  localparam int unsigned SplitW = MagW / 2;
  localparam int unsigned PartW  = MagW + SplitW;
  localparam int unsigned PW     = 2 * MagW;
  localparam int unsigned DW     = PW + 32;

  // Square-root search: t in 0..65536
  localparam int unsigned TBits  = 17;
  localparam int unsigned RW     = DW + 2;
  localparam int unsigned QW     = PW + TBits + 1;

  // Result
  localparam int unsigned ValW   = 16;
  localparam logic [ValW-1:0] ValMinusOne = 16'h8000;
  localparam logic [ValW-1:0] ValSatMax   = 16'h7FFF;
  localparam logic [ValW-1:0] ValZero     = 16'h0000;

  // Accept to result strobe, in cycles
  localparam int unsigned Latency = 7 + TBits;

  typedef enum logic [1:0] {
    ACT_LOAD_OBJ = 2'd0,
    ACT_LOAD_LBL = 2'd1,
    ACT_QUERY    = 2'd2,
    ACT_NONE     = 2'd3
  } ppcc_action_e;

  // Side-band record that travels with a query
  typedef struct packed {
    logic            forced;
    logic [ValW-1:0] fval;
    logic            zl;
    logic            neg;
  } ppcc_side_t;

endpackage
`default_nettype wire

// File: sv/ppcc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_ram: point table
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ppcc_ram (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    waddr_i,
  input  wire  [ppcc_pkg::PointW-1:0]  wdata_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    raddr_a_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    raddr_b_i,
  output logic [ppcc_pkg::PointW-1:0]  rdata_a_o,
  output logic [ppcc_pkg::PointW-1:0]  rdata_b_o
);
  import ppcc_pkg::*;

  logic [PointW-1:0] mem_q [Depth];

  // Write a loaded point
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read both query points
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// File: sv/ppcc_dot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_dot: difference vectors, dot product and squared lengths
// Five register stages: differences, products, sums, split 34x17 partial
// products, then P = |Vo|^2*|Vl|^2 and D = dot^2 * 2^32.
// ----------------------------------------------------------------------------
module ppcc_dot (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          vld_i,
  input  ppcc_pkg::ppcc_side_t         side_i,
  input  wire  [ppcc_pkg::PointW-1:0]  oa_i,
  input  wire  [ppcc_pkg::PointW-1:0]  ob_i,
  input  wire  [ppcc_pkg::PointW-1:0]  la_i,
  input  wire  [ppcc_pkg::PointW-1:0]  lb_i,
  output logic                         vld_o,
  output ppcc_pkg::ppcc_side_t         side_o,
  output logic [ppcc_pkg::PW-1:0]      p_o,
  output logic [ppcc_pkg::DW-1:0]      d_o
);
  import ppcc_pkg::*;

  logic [3:0]       vld_q;
  ppcc_side_t       side_q [4];

  logic signed [DiffW-1:0] vo_q [3];
  logic signed [DiffW-1:0] vl_q [3];
  logic signed [ProdW-1:0] pd_q [3];
  logic signed [ProdW-1:0] so_q [3];
  logic signed [ProdW-1:0] sl_q [3];
  logic [MagW-1:0]         adot_q, no2_q, nl2_q;
  logic [PartW-1:0]        dlo_q, dhi_q, plo_q, phi_q;

  logic signed [SumW-1:0]  dot_d;
  logic [MagW-1:0]         no2_d, nl2_d;
  logic signed [SumW-1:0]  nabs_d;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Sum the three components
  always_comb begin
    dot_d = '0;
    no2_d = '0;
    nl2_d = '0;
    for (int c = 0; c < 3; c++) begin
      dot_d = dot_d + SumW'(pd_q[c]);
      no2_d = no2_d + MagW'(so_q[c]);
      nl2_d = nl2_d + MagW'(sl_q[c]);
    end
    nabs_d = -dot_d;
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      vo_q[c] <= DiffW'($signed(ob_i[c*CoordW +: CoordW]))
               - DiffW'($signed(oa_i[c*CoordW +: CoordW]));
      vl_q[c] <= DiffW'($signed(lb_i[c*CoordW +: CoordW]))
               - DiffW'($signed(la_i[c*CoordW +: CoordW]));
      pd_q[c] <= vo_q[c] * vl_q[c];
      so_q[c] <= vo_q[c] * vo_q[c];
      sl_q[c] <= vl_q[c] * vl_q[c];
    end
    side_q[0] <= side_i;
    side_q[1] <= side_q[0];
    // Sums, sign and zero-length check
    side_q[2].forced <= side_q[1].forced;
    side_q[2].fval   <= side_q[1].fval;
    side_q[2].neg    <= dot_d[SumW-1];
    side_q[2].zl     <= (no2_d == '0) || (nl2_d == '0);
    adot_q <= dot_d[SumW-1] ? nabs_d[MagW-1:0] : dot_d[MagW-1:0];
    no2_q  <= no2_d;
    nl2_q  <= nl2_d;
    // Partial products
    side_q[3] <= side_q[2];
    dlo_q <= adot_q * PartW'(adot_q[SplitW-1:0]);
    dhi_q <= adot_q * PartW'(adot_q[MagW-1:SplitW]);
    plo_q <= no2_q * PartW'(nl2_q[SplitW-1:0]);
    phi_q <= no2_q * PartW'(nl2_q[MagW-1:SplitW]);
    // Combine
    side_o <= side_q[3];
    p_o    <= PW'(plo_q) + (PW'(phi_q) << SplitW);
    d_o    <= DW'(PW'(dlo_q) + (PW'(dhi_q) << SplitW)) << 32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_q[3];
    end
  end

endmodule
`default_nettype wire

// File: sv/ppcc_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_isqrt: pipelined search for t = floor(sqrt(D / P))
// One result bit per stage, most significant first. Each stage keeps the
// residual R = D - t^2*P and Q = t*P, so a trial is one add and compare.
// ----------------------------------------------------------------------------
module ppcc_isqrt (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          vld_i,
  input  ppcc_pkg::ppcc_side_t         side_i,
  input  wire  [ppcc_pkg::PW-1:0]      p_i,
  input  wire  [ppcc_pkg::DW-1:0]      d_i,
  output logic                         vld_o,
  output ppcc_pkg::ppcc_side_t         side_o,
  output logic [ppcc_pkg::TBits-1:0]   t_o
);
  import ppcc_pkg::*;

  logic             vld_q  [TBits+1];
  ppcc_side_t       side_q [TBits+1];
  logic [RW-1:0]    r_q    [TBits+1];
  logic [QW-1:0]    q_q    [TBits+1];
  logic [PW-1:0]    p_q    [TBits+1];
  logic [TBits-1:0] t_q    [TBits+1];

  // Stage inputs
  always_comb begin
    vld_q[0]  = vld_i;
    side_q[0] = side_i;
    r_q[0]    = RW'(d_i);
    q_q[0]    = '0;
    p_q[0]    = p_i;
    t_q[0]    = '0;
  end

  for (genvar g = 0; g < TBits; g++) begin : g_stage
    localparam int unsigned Bit = TBits - 1 - g;
    logic [RW-1:0] trial;
    logic          fit;

    // Try setting this bit of t
    always_comb begin
      trial = (RW'(q_q[g]) << (Bit + 1)) + (RW'(p_q[g]) << (2 * Bit));
      fit   = r_q[g] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    // Keep or drop the trial bit
    always_ff @(posedge clk_i) begin
      side_q[g+1] <= side_q[g];
      p_q[g+1]    <= p_q[g];
      if (fit) begin
        r_q[g+1] <= r_q[g] - trial;
        q_q[g+1] <= q_q[g] + (QW'(p_q[g]) << Bit);
        t_q[g+1] <= t_q[g] | (TBits'(1) << Bit);
      end else begin
        r_q[g+1] <= r_q[g];
        q_q[g+1] <= q_q[g];
        t_q[g+1] <= t_q[g];
      end
    end
  end

  assign vld_o  = vld_q[TBits];
  assign side_o = side_q[TBits];
  assign t_o    = t_q[TBits];

endmodule
`default_nettype wire

// File: sv/point_pair_cosine_compatibility.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_pair_cosine_compatibility: cosine compatibility of point pairs
// Two point tables and a fully pipelined cosine datapath.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start_i high and busy_o low;
//   busy_o stays low, so one item can be taken every cycle.
//   Load items (object or label) write one point into a table and give no
//   result. A query reads both tables at once (two read ports per table)
//   and gives one result, marked by done_o for one cycle, registered after
//   the square-root search. Results leave in the order the queries came in.
//   Throughput: one item per cycle; the cosine is computed by a pipeline of
//   five product stages followed by a 17-stage bit-per-stage square-root
//   search, so no stage is shared between items.
//   A query may follow the load of the entry it reads in the next cycle.
//   The receiver cannot stall: results must be taken when done_o is high.
//   Reset clears the pipeline valid bits; table contents are undefined
//   until written.
// ----------------------------------------------------------------------------
module point_pair_cosine_compatibility (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [1:0]                   action_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    load_index_i,
  input  wire  [ppcc_pkg::CoordW-1:0]  coord_x_i,
  input  wire  [ppcc_pkg::CoordW-1:0]  coord_y_i,
  input  wire  [ppcc_pkg::CoordW-1:0]  coord_z_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    first_object_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    first_label_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    second_object_i,
  input  wire  [ppcc_pkg::IdxW-1:0]    second_label_i,
  output logic                         done_o,
  output logic [ppcc_pkg::ValW-1:0]    compat_value_o,
  output logic                         zero_length_o
);
  import ppcc_pkg::*;

  logic              acc;
  logic              qry_acc;
  ppcc_action_e      act;
  logic [PointW-1:0] wpoint;
  logic [PointW-1:0] oa, ob, la, lb;
  logic              rd_vld_q;
  ppcc_side_t        rd_side_q;
  logic              dot_vld;
  ppcc_side_t        dot_side;
  logic [PW-1:0]     dot_p;
  logic [DW-1:0]     dot_d;
  logic              sq_vld;
  ppcc_side_t        sq_side;
  logic [TBits-1:0]  sq_t;
  logic [TBits-1:0]  mag;
  logic [TBits-1:0]  nmag;
  logic [ValW-1:0]   val_d;

  assign busy_o  = 1'b0;
  assign act     = ppcc_action_e'(action_i);
  assign acc     = start_i && !busy_o;
  assign qry_acc = acc && (act == ACT_QUERY);
  assign wpoint  = {coord_z_i, coord_y_i, coord_x_i};

  // Point tables
  ppcc_ram u_obj_ram (
    .clk_i     (clk_i),
    .we_i      (acc && (act == ACT_LOAD_OBJ)),
    .waddr_i   (load_index_i),
    .wdata_i   (wpoint),
    .raddr_a_i (first_object_i),
    .raddr_b_i (second_object_i),
    .rdata_a_o (oa),
    .rdata_b_o (ob)
  );

  ppcc_ram u_lbl_ram (
    .clk_i     (clk_i),
    .we_i      (acc && (act == ACT_LOAD_LBL)),
    .waddr_i   (load_index_i),
    .wdata_i   (wpoint),
    .raddr_a_i (first_label_i),
    .raddr_b_i (second_label_i),
    .rdata_a_o (la),
    .rdata_b_o (lb)
  );

  // Hold the query beside the table read; resolve matching indexes here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= qry_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_side_q.forced <= (first_object_i == second_object_i)
                     || (first_label_i == second_label_i);
    rd_side_q.fval   <= ((first_object_i == second_object_i)
                     && (first_label_i == second_label_i)) ? ValZero : ValMinusOne;
    rd_side_q.zl     <= 1'b0;
    rd_side_q.neg    <= 1'b0;
  end

  ppcc_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .side_i (rd_side_q),
    .oa_i   (oa),
    .ob_i   (ob),
    .la_i   (la),
    .lb_i   (lb),
    .vld_o  (dot_vld),
    .side_o (dot_side),
    .p_o    (dot_p),
    .d_o    (dot_d)
  );

  ppcc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dot_vld),
    .side_i (dot_side),
    .p_i    (dot_p),
    .d_i    (dot_d),
    .vld_o  (sq_vld),
    .side_o (sq_side),
    .t_o    (sq_t)
  );

  // Round, apply sign and saturate; forced values and zero length win
  always_comb begin
    mag  = (sq_t + TBits'(1)) >> 1;
    nmag = TBits'(0) - mag;
    if (sq_side.forced) begin
      val_d = sq_side.fval;
    end else if (sq_side.zl) begin
      val_d = ValZero;
    end else if (sq_side.neg) begin
      val_d = nmag[ValW-1:0];
    end else if (mag > TBits'(ValSatMax)) begin
      val_d = ValSatMax;
    end else begin
      val_d = mag[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    compat_value_o <= val_d;
    zero_length_o  <= !sq_side.forced && sq_side.zl;
  end

  // Checks
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qry_acc |-> ##Latency done_o)
    else $error("query gave no result at the expected latency");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(qry_acc, Latency))
    else $error("result without a matching query");

  a_zero_len_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_length_o) |-> (compat_value_o == ValZero))
    else $error("zero-length result with nonzero value");

endmodule
`default_nettype wire
